@@ sv/ctd_pkg.sv @@
// ============================================================================
// ctd_pkg
// Shared types and constants for the chunked transfer decoder.
// ============================================================================
package ctd_pkg;

    // Input beat: one raw body byte with its end-of-body mark.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       last_byte;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_body;
        logic [2:0] end_status;
    } t_out_item;

    // End status codes
    localparam logic [2:0] ST_RUNNING     = 3'd0;
    localparam logic [2:0] ST_FINAL_CHUNK = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_END_BETWEEN = 3'd4;
    localparam logic [2:0] ST_END_INSIDE  = 3'd5;

    // Framing characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Register map: 32-bit words, paddr[2] picks the word; word 0 holds the mode
    localparam int         CFG_ADDR_W       = 3;
    localparam logic       REG_CHUNKED_MODE = 1'b0;

endpackage

@@ sv/chunked_transfer_decoder.sv @@
// ============================================================================
// chunked_transfer_decoder
// HTTP chunked transfer decoder for message body bytes, one byte per beat.
// ============================================================================
// Takes one body byte per beat and returns at most one result beat for it.
// Throughput is one byte per clock while the result side is not stalled.
// An accepted input beat waits in the input register; the decode step then
// writes the result register. The decode step is a small framing FSM with a
// SIZE_BITS-wide chunk counter, updated once per byte, so bytes can follow
// each other on every cycle. Bytes that produce no result (size line, CRLF,
// bytes after the body closed) are absorbed without waiting on the output.
// A stalled result is held in the output register while the next byte is
// still accepted into the input register. Write chunked_mode (address 0)
// only while the block is idle; there is no clearing pass after reset.
// ============================================================================
module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // input byte beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,

    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic      r_chunked_mode;
    logic      cfg_wr;

    logic      q_valid;
    t_in_item  q_item;
    logic      adv;
    logic      emit;
    t_out_item res;
    logic      out_free;

    // ---- configuration register ----
    // Zero-wait port; only word 0 holds a register, others read as zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHUNKED_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= 1'b1;
        end else if (cfg_wr) begin
            r_chunked_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_CHUNKED_MODE) ? {31'd0, r_chunked_mode} : 32'd0;

    // ---- datapath ----
    // Advance the held byte when it makes no result, or when the result
    // register is empty or being drained this cycle.
    assign adv = q_valid && (!emit || out_free);

    ctd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_adv   (adv),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    ctd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_chunked_mode),
        .i_adv   (adv),
        .i_item  (q_item),
        .o_emit  (emit),
        .o_res   (res)
    );

    ctd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && emit),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

@@ sv/ctd_in_stage.sv @@
// ============================================================================
// ctd_in_stage
// Input register: holds one accepted beat until the decode step takes it.
// ============================================================================
module ctd_in_stage
    import ctd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     load;

    assign o_stall = r_valid && !i_adv;
    assign load    = i_valid && !o_stall;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/ctd_core.sv @@
// ============================================================================
// ctd_core
// Framing state and the per-byte decode step: size line, data, trailing CRLF.
// ============================================================================
module ctd_core
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mode,
    input  logic      i_adv,
    input  t_in_item  i_item,
    output logic      o_emit,
    output t_out_item o_res
);

    typedef enum logic [6:0] {
        PH_SIZE     = 7'b0000001,
        PH_EXT      = 7'b0000010,
        PH_SIZE_LF  = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_TRAIL_CR = 7'b0010000,
        PH_TRAIL_LF = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [SIZE_BITS-1:0] r_count;
    logic [SIZE_BITS-1:0] n_count;
    logic                 r_seen;
    logic                 n_seen;

    logic [7:0]           b;
    logic                 is_hex;
    logic [3:0]           nib;

    // size-line byte outcome
    t_phase               sl_phase;
    logic [SIZE_BITS-1:0] sl_count;
    logic                 sl_seen;
    logic [2:0]           sl_st;

    logic [SIZE_BITS-1:0] dec_count;
    logic [7:0]           data;
    logic                 has;
    logic                 fin;
    logic [2:0]           st;
    logic                 quiet;

    assign b = i_item.body_byte;

    // hex digit decode
    always_comb begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            nib = 4'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            nib = 4'(b - 8'h57);
        end else if (b inside {[8'h41:8'h46]}) begin
            nib = 4'(b - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    // one byte of the size-gathering part of a line
    always_comb begin
        sl_phase = PH_SIZE;
        sl_count = r_count;
        sl_seen  = r_seen;
        sl_st    = ST_RUNNING;
        if (is_hex) begin
            if (|r_count[SIZE_BITS-1 -: 4]) begin
                sl_st = ST_OVERFLOW;
            end else begin
                sl_count = {r_count[SIZE_BITS-5:0], nib};
                sl_seen  = 1'b1;
            end
        end else if ((b == CH_SP || b == CH_TAB) && !r_seen) begin
            sl_phase = PH_SIZE;
        end else if (b == CH_CR) begin
            sl_phase = PH_SIZE_LF;
        end else begin
            sl_phase = PH_EXT;
        end
    end

    assign dec_count = (r_count != '0) ? r_count - SIZE_BITS'(1) : r_count;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_seen  = r_seen;
        data    = 8'd0;
        has     = 1'b0;
        fin     = 1'b0;
        st      = ST_RUNNING;
        quiet   = 1'b0;

        if (!i_mode) begin
            has  = 1'b1;
            data = b;
            if (i_item.last_byte) begin
                fin = 1'b1;
                st  = ST_END_INSIDE;
            end
        end else begin
            case (r_phase)
                PH_DONE: begin
                    quiet = 1'b1;
                end
                PH_DATA: begin
                    data    = b;
                    has     = 1'b1;
                    n_count = dec_count;
                    if (dec_count == '0) begin
                        n_phase = PH_TRAIL_CR;
                        n_seen  = 1'b0;
                    end
                end
                PH_TRAIL_CR: begin
                    if (b == CH_CR) begin
                        n_phase = PH_TRAIL_LF;
                    end else begin
                        n_phase = sl_phase;
                        n_count = sl_count;
                        n_seen  = sl_seen;
                        st      = sl_st;
                    end
                end
                PH_TRAIL_LF: begin
                    if (b == CH_LF) begin
                        n_phase = PH_SIZE;
                    end else begin
                        n_phase = sl_phase;
                        n_count = sl_count;
                        n_seen  = sl_seen;
                        st      = sl_st;
                    end
                end
                PH_EXT: begin
                    if (b == CH_CR) begin
                        n_phase = PH_SIZE_LF;
                    end
                end
                PH_SIZE_LF: begin
                    if (b == CH_LF) begin
                        if (!r_seen) begin
                            st = ST_BAD_SIZE;
                        end else if (r_count == '0) begin
                            st = ST_FINAL_CHUNK;
                        end else begin
                            n_phase = PH_DATA;
                            n_seen  = 1'b0;
                        end
                    end else if (b != CH_CR) begin
                        n_phase = PH_EXT;
                    end
                end
                default: begin
                    n_phase = sl_phase;
                    n_count = sl_count;
                    n_seen  = sl_seen;
                    st      = sl_st;
                end
            endcase

            if (!quiet) begin
                if (st != ST_RUNNING) begin
                    fin     = 1'b1;
                    n_phase = PH_DONE;
                end
                // body cut short by the end mark
                if (i_item.last_byte && !fin) begin
                    fin = 1'b1;
                    st  = (n_phase == PH_DATA) ? ST_END_INSIDE : ST_END_BETWEEN;
                end
            end
        end

        // end mark always returns to the start of a new body
        if (i_item.last_byte) begin
            n_phase = PH_SIZE;
            n_count = '0;
            n_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_count <= '0;
            r_seen  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_seen  <= n_seen;
        end
    end

    assign o_emit            = has || fin;
    assign o_res.data_byte   = data;
    assign o_res.has_data    = has;
    assign o_res.end_of_body = fin;
    assign o_res.end_status  = st;

endmodule

@@ sv/ctd_out_stage.sv @@
// ============================================================================
// ctd_out_stage
// Result register: holds one result beat until the sink takes it.
// ============================================================================
module ctd_out_stage
    import ctd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/ctd_checker.sv @@
// ============================================================================
// ctd_checker
// Port-level checks on the result channel of the chunked transfer decoder.
// ============================================================================
module ctd_checker
    import ctd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // a status is reported exactly on a closing beat
    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.end_of_body == (o_out_item.end_status != ST_RUNNING)))
        else $error("end status and end of body disagree");

    // every result beat carries data or closes the body
    a_no_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.has_data || o_out_item.end_of_body))
        else $error("empty result beat");

    // no stray data byte on a beat without data
    a_clean_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.has_data |-> (o_out_item.data_byte == 8'd0))
        else $error("data byte set without data");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the chunked transfer decoder.
// ============================================================================
// A clocked driver offers body-byte beats from a queue that the stimulus
// process fills. At each accepted beat a framing model in this file works out
// the result beat, if any, and queues it. A clocked monitor takes each
// accepted result beat and compares it field by field with the oldest
// prediction. The run walks through chunked decoding, pass-through and
// chunked decoding again, each with its own idling pattern, and reprograms
// the mode register only while the block is drained.
// ============================================================================
module tb_top;
    import ctd_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 6;        // input and result registers plus margin
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [CFG_ADDR_W-1:0] ADDR_MODE   = {REG_CHUNKED_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

    // Framing states of the size-line / chunk-data parser
    typedef enum logic [2:0] {
        FR_SIZE,
        FR_EXT,
        FR_SIZE_LF,
        FR_DATA,
        FR_TRAIL_CR,
        FR_TRAIL_LF,
        FR_DONE
    } t_frame_phase;

    logic                  i_clk;
    logic                  i_rst_n;

    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              in_beat  = '0;

    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             o_out_item;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    chunked_transfer_decoder #(
        .SIZE_BITS (SIZE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_in_item     body_stream[$];       // beats waiting for the driver
    t_out_item    predicted_beats[$];   // result beats still owed by the block
    logic [7:0]   body_bytes[$];        // scratch body under construction
    int           queued_count   = 0;
    int           error_count    = 0;
    int           cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           hold_requests  = 0;   // bumped by stimulus
    int           hold_served    = 0;   // bumped by the hold counter
    int           hold_left      = 0;

    // Framing model state, mirrors the block's own
    logic                 chunked_on;
    t_frame_phase         frame_phase;
    logic [SIZE_BITS-1:0] frame_count;
    logic                 digit_seen;

    // ------------------------------------------------------------------------
    // Framing model
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        frame_phase = FR_SIZE;
        frame_count = '0;
        digit_seen  = 1'b0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    // One byte of the size field; returns a closing status or ST_RUNNING.
    function automatic logic [2:0] take_size_char(input logic [7:0] b);
        int nib;
        nib = hex_nibble(b);
        if (nib >= 0) begin
            // Another digit would push the count past its width
            if (frame_count[SIZE_BITS-1 -: 4] != 4'd0) return ST_OVERFLOW;
            frame_count = {frame_count[SIZE_BITS-5:0], nib[3:0]};
            digit_seen  = 1'b1;
        end else if ((b == CH_SP || b == CH_TAB) && !digit_seen) begin
            // leading blank: skip
        end else if (b == CH_CR) begin
            frame_phase = FR_SIZE_LF;
        end else begin
            frame_phase = FR_EXT;
        end
        return ST_RUNNING;
    endfunction

    // Advance the model by one accepted beat and queue its result, if any.
    function automatic void decode_beat(input t_in_item beat);
        t_out_item  res;
        logic [2:0] st;
        logic [7:0] b;
        res = '0;
        st  = ST_RUNNING;
        b   = beat.body_byte;
        if (!chunked_on) begin
            res.data_byte = b;
            res.has_data  = 1'b1;
            if (beat.last_byte) begin
                res.end_of_body = 1'b1;
                res.end_status  = ST_END_INSIDE;
                clear_frame();
            end
        end else if (frame_phase == FR_DONE) begin
            // Body already closed: swallow bytes up to the end mark
            if (beat.last_byte) clear_frame();
            return;
        end else begin
            case (frame_phase)
                FR_DATA: begin
                    res.data_byte = b;
                    res.has_data  = 1'b1;
                    if (frame_count != '0) frame_count = frame_count - SIZE_BITS'(1);
                    if (frame_count == '0) begin
                        frame_phase = FR_TRAIL_CR;
                        digit_seen  = 1'b0;
                    end
                end
                FR_TRAIL_CR: begin
                    if (b == CH_CR) begin
                        frame_phase = FR_TRAIL_LF;
                    end else begin
                        frame_phase = FR_SIZE;
                        st = take_size_char(b);
                    end
                end
                FR_TRAIL_LF: begin
                    frame_phase = FR_SIZE;
                    if (b != CH_LF) st = take_size_char(b);
                end
                FR_EXT: begin
                    if (b == CH_CR) frame_phase = FR_SIZE_LF;
                end
                FR_SIZE_LF: begin
                    if (b == CH_LF) begin
                        if (!digit_seen) begin
                            st = ST_BAD_SIZE;
                        end else if (frame_count == '0) begin
                            st = ST_FINAL_CHUNK;
                        end else begin
                            frame_phase = FR_DATA;
                            digit_seen  = 1'b0;
                        end
                    end else if (b != CH_CR) begin
                        frame_phase = FR_EXT;
                    end
                end
                default: begin
                    frame_phase = FR_SIZE;
                    st = take_size_char(b);
                end
            endcase
            if (st != ST_RUNNING) begin
                res.end_of_body = 1'b1;
                frame_phase     = FR_DONE;
            end
            // End mark on a still-open body closes it here
            if (beat.last_byte && !res.end_of_body) begin
                res.end_of_body = 1'b1;
                st = (frame_phase == FR_DATA) ? ST_END_INSIDE : ST_END_BETWEEN;
            end
            res.end_status = st;
            if (beat.last_byte) clear_frame();
        end
        if (res.has_data || res.end_of_body)
            predicted_beats.insert(predicted_beats.size(), res);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer the next beat whenever the current one is gone.
    // The decision to idle never looks at the stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) decode_beat(in_beat);
            if (!in_valid || !o_in_stall) begin
                if (body_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= body_stream.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Hold counter: a long receiver hold-off, counted in cycles.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result beat, then pick the next stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (predicted_beats.size() == 0) begin
                    $display("%0t: result beat with none pending: ", $time,
                             "data=%h has=%b end=%b st=%0d",
                             o_out_item.data_byte, o_out_item.has_data,
                             o_out_item.end_of_body, o_out_item.end_status);
                    error_count++;
                end else begin
                    want = predicted_beats.pop_front();
                    if (o_out_item.data_byte   !== want.data_byte   ||
                        o_out_item.has_data    !== want.has_data    ||
                        o_out_item.end_of_body !== want.end_of_body ||
                        o_out_item.end_status  !== want.end_status) begin
                        $display("%0t: mismatch exp data=%h has=%b end=%b st=%0d",
                                 $time, want.data_byte, want.has_data,
                                 want.end_of_body, want.end_status,
                                 " | got data=%h has=%b end=%b st=%0d",
                                 o_out_item.data_byte, o_out_item.has_data,
                                 o_out_item.end_of_body, o_out_item.end_status);
                        error_count++;
                    end
                end
            end
            // Long hold-off: back up the block until it stalls its input
            if (hold_left > 0 || hold_requests != hold_served) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("chunked_transfer_decoder verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input int nib, input bit upper);
        if (nib < 10) return 8'(int'("0") + nib);
        if (upper) return 8'(int'("A") + nib - 10);
        return 8'(int'("a") + nib - 10);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        body_bytes.insert(body_bytes.size(), b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void add_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    // Move the scratch body into the beat queue, end mark on its final byte.
    function automatic void push_body();
        t_in_item beat;
        for (int i = 0; i < body_bytes.size(); i++) begin
            beat.body_byte = body_bytes[i];
            beat.last_byte = (i == body_bytes.size() - 1);
            body_stream.insert(body_stream.size(), beat);
        end
        queued_count += body_bytes.size();
        body_bytes.delete();
    endfunction

    // Size line with random blanks, case, leading zeros, extension and ending.
    function automatic void add_size_line(input logic [31:0] size);
        int          n_digit;
        int          pick;
        logic [31:0] rest;
        n_digit = 1;
        rest    = size >> 4;
        while (rest != 0) begin
            n_digit++;
            rest = rest >> 4;
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2))
                put_byte($urandom_range(1) ? CH_SP : CH_TAB);
        if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) put_byte("0");
        for (int i = n_digit - 1; i >= 0; i--)
            put_byte(hex_char(int'(size[4*i +: 4]), 1'($urandom_range(1))));
        if ($urandom_range(3) == 0) begin
            put_byte($urandom_range(1) ? ";" : CH_SP);
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            put_byte(CH_CR);                    // CR CR LF still ends the line
        end else if (pick == 1) begin
            put_byte(CH_CR);                    // CR then junk: back to extension
            put_byte("z");
        end
        add_crlf();
    endfunction

    function automatic void add_chunked_body();
        int unsigned size;
        int          pick;
        repeat ($urandom_range(1, 4)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            add_size_line(size);
            repeat (size) put_byte(8'($urandom_range(255)));
            pick = $urandom_range(9);
            if (pick < 8) begin
                add_crlf();
            end else if (pick == 8) begin
                put_byte(CH_CR);
            end
        end
        add_size_line(0);
        if ($urandom_range(3) == 0) begin
            add_text("T:1");
            add_crlf();
        end
        add_crlf();
    endfunction

    // Mostly well-formed bodies with random content; the rest is broken.
    task automatic fill_chunked(input int target);
        int goal;
        int pick;
        int cut;
        goal = queued_count + target;
        while (queued_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                add_chunked_body();
            end else if (pick < 82) begin
                // truncated body
                add_chunked_body();
                cut = $urandom_range(1, body_bytes.size());
                while (body_bytes.size() > cut) void'(body_bytes.pop_back());
            end else if (pick < 88) begin
                // size line with no digit
                if ($urandom_range(1)) put_byte(CH_SP);
                if ($urandom_range(1)) add_text(";x");
                add_crlf();
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(255)));
            end else if (pick < 94) begin
                // size too wide for the counter
                put_byte(hex_char(int'($urandom_range(1, 15)), 1'($urandom_range(1))));
                repeat ($urandom_range(8, 9))
                    put_byte(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))));
                add_crlf();
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
            end
            push_body();
        end
    endtask

    task automatic fill_passthrough(input int target);
        int goal;
        goal = queued_count + target;
        while (queued_count < goal) begin
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(255)));
            push_body();
        end
    endtask

    // Hold the sender until every beat is in and every result is out.
    // Recheck after the margin: a beat popped in the sampling step may
    // not show its valid yet.
    task automatic wait_drained();
        do begin
            while (body_stream.size() != 0 || in_valid || predicted_beats.size() != 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end while (body_stream.size() != 0 || in_valid || predicted_beats.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE) chunked_on = value[0];
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_item beat;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        chunked_on = 1'b1;
        clear_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Chunked decoding; the write to the spare slot must change nothing
        cfg_write(ADDR_UNUSED, 32'h0);
        cfg_write(ADDR_MODE, ($urandom & 32'hFFFF_FFFE) | 32'h1);
        send_idle_pct <= 6;
        recv_idle_pct <= 85;

        add_text("\t2;e\r\r\nA");       // tab, extension, CR CR LF, cut inside chunk
        push_body();
        add_text(" \r\n");              // blank line without digits
        push_body();
        add_text("1\rz\r\nQ0\r\nx");    // CR then junk, no CR LF after data, trailer
        push_body();
        add_text("1\r\nZ");             // end mark on the chunk's last data byte
        push_body();
        add_text("Fedcba987x");         // ninth digit overflows, rest ignored
        push_body();

        fill_chunked(300);
        wait_drained();
        fill_chunked(350);
        wait_drained();

        // Pass-through with a long receiver hold-off at its start
        cfg_write(ADDR_MODE, $urandom & 32'hFFFF_FFFE);
        send_idle_pct <= 85;
        recv_idle_pct <= 6;
        hold_requests <= hold_requests + 1;
        beat.body_byte = 8'h00;
        beat.last_byte = 1'b1;
        body_stream.insert(body_stream.size(), beat);
        beat.body_byte = 8'hFF;
        beat.last_byte = 1'b0;
        body_stream.insert(body_stream.size(), beat);
        fill_passthrough(650);
        wait_drained();

        // Back to chunked decoding, no idling on either side
        cfg_write(ADDR_MODE, 32'h1);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        fill_chunked(650);
        wait_drained();

        if (predicted_beats.size() != 0) begin
            want_left: begin
                $display("%0t: mismatch exp data=%h has=%b end=%b st=%0d | got none",
                         $time, predicted_beats[0].data_byte, predicted_beats[0].has_data,
                         predicted_beats[0].end_of_body, predicted_beats[0].end_status);
            end
        end
        if (error_count == 0 && predicted_beats.size() == 0) begin
            $display("chunked_transfer_decoder verification clean");
        end else begin
            $display("chunked_transfer_decoder verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ctd_pkg.sv
sv/ctd_in_stage.sv
sv/ctd_core.sv
sv/ctd_out_stage.sv
sv/chunked_transfer_decoder.sv
sv/ctd_checker.sv
bench/tb_top.sv
